[hdl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions of the LRU key/value cache
// Sizes, operation codes and the item types passed between the stages.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W  = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic signed [KEY_W-1:0]   key;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [DATA_W-1:0]  read_value;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/lkvc_ifs.sv]
// ----------------------------------------------------------------------------
// lkvc_ifs: channel interfaces of the LRU key/value cache
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_in_if import lkvc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [KEY_W-1:0]  key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkvc_out_if import lkvc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_cfg_if import lkvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/lkvc_in_reg.sv]
// ----------------------------------------------------------------------------
// lkvc_in_reg: request input register
// Holds one accepted request until the lookup stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_in_reg import lkvc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic req_valid,
  output req_t req,
  input  logic req_take
);

  logic valid_r;
  logic valid_nxt;
  req_t req_r;

  assign in_ready  = !valid_r || req_take;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (req_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

endmodule

`default_nettype wire

[hdl/lkvc_core.sv]
// ----------------------------------------------------------------------------
// lkvc_core: entry array, parallel key match and recency update
// Looks up the request against all entries and updates keys, values, valid
// bits, recency ranks and the fill count in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_core import lkvc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  req_t             req,
  input  logic             out_free,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             req_take,
  output logic             rsp_valid,
  output rsp_t             rsp
);

  logic [KEY_W-1:0]   key_store_r   [ENTRIES];
  logic [DATA_W-1:0]  value_store_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [RANK_W-1:0]  rank_r   [ENTRIES];
  logic [RANK_W-1:0]  rank_nxt [ENTRIES];
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  fill_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CAP_W-1:0]   cap_nxt;

  logic [FILL_W-1:0]  eff_cap;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] valid_ev;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] key_we;
  logic [ENTRIES-1:0] value_we;
  logic [RANK_W-1:0]  hit_rank;
  logic [RANK_W-1:0]  victim_rank;
  logic [DATA_W-1:0]  hit_value;
  logic               hit;
  logic               evict;
  logic               is_put;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = FILL_W'(1);
    end else if (32'(cap_r) > ENTRIES) begin
      eff_cap = FILL_W'(ENTRIES);
    end else begin
      eff_cap = FILL_W'(cap_r);
    end

    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_store_r[i] == req.key);
      if (match[i]) begin
        hit_rank  = hit_rank | rank_r[i];
        hit_value = hit_value | value_store_r[i];
      end
    end
    hit = |match;

    // The valid entries always hold the ranks 0 to fill-1, so the oldest
    // entry is the one whose rank equals fill-1.
    evict       = (fill_r >= eff_cap);
    victim_rank = RANK_W'(fill_r - FILL_W'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = evict && valid_r[i] && (rank_r[i] == victim_rank);
    end
    valid_ev = valid_r & ~victim;
    free     = ~valid_ev & (valid_ev + ENTRIES'(1));

    is_put   = (req.func == FUNC_PUT);
    req_take = req_valid && (is_put || out_free);

    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    fill_nxt  = fill_r;
    key_we    = '0;
    value_we  = '0;

    if (req_take) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
        if (is_put) begin
          value_we = match;
        end
      end else if (is_put) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (free[i] || victim[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_ev[i]) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
        valid_nxt = valid_ev | free;
        key_we    = free;
        value_we  = free;
        if (!evict) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
      end
    end

    cap_nxt = cfg_we ? cfg_data : cap_r;

    rsp_valid      = req_take && !is_put;
    rsp.hit        = hit;
    rsp.read_value = hit_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      cap_r   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      cap_r   <= cap_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_we[i]) begin
        key_store_r[i] <= req.key;
      end
      if (value_we[i]) begin
        value_store_r[i] <= req.value;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(ENTRIES))
    else $error("fill count exceeds the number of entries");

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(fill_r))
    else $error("fill count differs from the number of valid entries");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key matches more than one entry");

  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && is_put && !hit) |-> $onehot(free))
    else $error("insert found no free entry");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && is_put && !hit && !evict) |=> (fill_r == $past(fill_r) + FILL_W'(1)))
    else $error("insert without eviction did not grow the fill count");
`endif

endmodule

`default_nettype wire

[hdl/lkvc_out_reg.sv]
// ----------------------------------------------------------------------------
// lkvc_out_reg: result output register
// Holds one lookup result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_out_reg import lkvc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic rsp_valid,
  input  rsp_t rsp,
  output logic out_free,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  logic valid_r;
  logic valid_nxt;
  rsp_t rsp_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

  always_comb begin
    valid_nxt = valid_r;
    if (rsp_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid) begin
      rsp_r <= rsp;
    end
  end

endmodule

`default_nettype wire

[hdl/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Input register, match and recency update, result register.
// ----------------------------------------------------------------------------
//   channel   direction   items
//   in_ch     sink        func, key, value
//   out_ch    source      hit, read_value (one per get, none per put)
//   cfg_ch    sink        data: capacity
//
// One item is accepted per cycle while no get waits in the input register; with
// the output register free, a waiting get is taken and its result is registered.
// The entry array is matched and updated as each item is taken, which sets the rate.
// Reset is synchronous and clears all valid bits, ranks and the fill count.
// A get waits in the input register while an untaken result blocks the
// output register; puts proceed regardless.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache import lkvc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lkvc_in_if.sink    in_ch,
  lkvc_out_if.source out_ch,
  lkvc_cfg_if.sink   cfg_ch
);

  req_t in_req;
  req_t req;
  rsp_t rsp;
  rsp_t out_rsp;
  logic req_valid;
  logic req_take;
  logic rsp_valid;
  logic out_free;

  assign in_req.func  = func_t'(in_ch.func);
  assign in_req.key   = in_ch.key;
  assign in_req.value = in_ch.value;

  assign cfg_ch.ready = 1'b1;

  assign out_ch.hit        = out_rsp.hit;
  assign out_ch.read_value = out_rsp.read_value;

  lkvc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_req    (in_req),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  lkvc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .out_free  (out_free),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .req_take  (req_take),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  lkvc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire
